@@ hw/rtl/pdl_pkg.sv @@
// Shared types and constants for the pass dependency leveler.
package pdl_pkg;

  localparam int MAX_PASSES    = 32;
  localparam int RESOURCE_BITS = 64;

  localparam int MASK_W   = 64;
  localparam int LEVEL_W  = 5;
  localparam int LCOUNT_W = 6;
  localparam int CNT_W    = $clog2(MAX_PASSES + 1);
  localparam int IDX_W    = $clog2(MAX_PASSES);

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 5'd31;

  typedef struct packed {
    logic [MASK_W-1:0] read_mask;
    logic [MASK_W-1:0] write_mask;
    logic              last_pass;
  } pdl_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  pass_level;
    logic [LCOUNT_W-1:0] level_count;
    logic                is_last;
    logic                overflow;
  } pdl_out_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
    logic emit;
  } pdl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;
    logic out_free;
  } pdl_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_COMMIT,
    ST_EMIT
  } pdl_state_t;

endpackage

@@ hw/rtl/pdl_ctrl.sv @@
// Sequencing state machine for the pass dependency leveler.
module pdl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pdl_pkg::pdl_stat_t stat,
  output pdl_pkg::pdl_cmd_t  cmd
);

  pdl_pkg::pdl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      pdl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.full) begin
            state_next = pdl_pkg::ST_EMIT;
          end else if (stat.empty) begin
            state_next = pdl_pkg::ST_COMMIT;
          end else begin
            state_next = pdl_pkg::ST_SCAN;
          end
        end
      end
      pdl_pkg::ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (stat.scan_last) begin
          state_next = pdl_pkg::ST_SCAN_END;
        end
      end
      // The last read's data is folded in during this cycle.
      pdl_pkg::ST_SCAN_END: begin
        state_next = pdl_pkg::ST_COMMIT;
      end
      pdl_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = pdl_pkg::ST_EMIT;
      end
      pdl_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = pdl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pdl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/pdl_dp.sv @@
// Datapath: pass store, dependency scan, level arithmetic and result register.
module pdl_dp (
  input  logic               clk,
  input  logic               rst,
  input  pdl_pkg::pdl_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pdl_pkg::pdl_out_t  out_data,
  input  pdl_pkg::pdl_cmd_t  cmd,
  output pdl_pkg::pdl_stat_t stat
);

  logic [pdl_pkg::RESOURCE_BITS-1:0] mask_mem [pdl_pkg::MAX_PASSES];
  logic [pdl_pkg::LEVEL_W-1:0]       lvl_mem  [pdl_pkg::MAX_PASSES];

  logic [pdl_pkg::CNT_W-1:0]         count;
  logic [pdl_pkg::LEVEL_W-1:0]       deepest;
  logic [pdl_pkg::IDX_W-1:0]         idx;

  logic [pdl_pkg::RESOURCE_BITS-1:0] rd_q;
  logic [pdl_pkg::RESOURCE_BITS-1:0] wr_q;
  logic                              last_q;
  logic                              ovf_q;

  logic [pdl_pkg::RESOURCE_BITS-1:0] rd_mask;
  logic [pdl_pkg::LEVEL_W-1:0]       rd_lvl;
  logic                              rd_vld;

  logic                              has_dep;
  logic [pdl_pkg::LEVEL_W-1:0]       deepest_dep;
  logic [pdl_pkg::LEVEL_W-1:0]       level;
  logic [pdl_pkg::LEVEL_W-1:0]       level_q;

  assign stat.full      = (count == pdl_pkg::CNT_W'(pdl_pkg::MAX_PASSES));
  assign stat.empty     = (count == '0);
  assign stat.scan_last = (pdl_pkg::CNT_W'(idx) == (count - pdl_pkg::CNT_W'(1)));
  assign stat.out_free  = !out_valid || !out_stall;

  // Level saturates at the top of the field.
  always_comb begin
    if (!has_dep) begin
      level = '0;
    end else if (deepest_dep == pdl_pkg::LEVEL_MAX) begin
      level = pdl_pkg::LEVEL_MAX;
    end else begin
      level = deepest_dep + pdl_pkg::LEVEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_mask <= mask_mem[idx];
      rd_lvl  <= lvl_mem[idx];
    end
    if (cmd.commit) begin
      mask_mem[count[pdl_pkg::IDX_W-1:0]] <= wr_q;
      lvl_mem[count[pdl_pkg::IDX_W-1:0]]  <= level;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_q   <= in_data.read_mask[pdl_pkg::RESOURCE_BITS-1:0];
      wr_q   <= in_data.write_mask[pdl_pkg::RESOURCE_BITS-1:0];
      last_q <= in_data.last_pass;
    end
    if (cmd.commit) begin
      level_q <= level;
    end else if (cmd.load) begin
      level_q <= '0;
    end
    if (cmd.emit) begin
      out_data.pass_level  <= level_q;
      out_data.level_count <= last_q ?
                              (pdl_pkg::LCOUNT_W'(deepest) + pdl_pkg::LCOUNT_W'(1)) : '0;
      out_data.is_last     <= last_q;
      out_data.overflow    <= ovf_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      deepest     <= '0;
      idx         <= '0;
      rd_vld      <= 1'b0;
      has_dep     <= 1'b0;
      deepest_dep <= '0;
      ovf_q       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      if (cmd.load) begin
        idx         <= '0;
        has_dep     <= 1'b0;
        deepest_dep <= '0;
        ovf_q       <= stat.full;
      end else begin
        if (cmd.rd_en) begin
          idx <= idx + pdl_pkg::IDX_W'(1);
        end
        // An earlier writer of any resource this pass reads is a dependency.
        if (rd_vld && |(rd_mask & rd_q)) begin
          has_dep <= 1'b1;
          if (rd_lvl > deepest_dep) begin
            deepest_dep <= rd_lvl;
          end
        end
      end
      if (cmd.commit) begin
        count <= count + pdl_pkg::CNT_W'(1);
        if (level > deepest) begin
          deepest <= level;
        end
      end
      if (cmd.emit && last_q) begin
        count   <= '0;
        deepest <= '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pdl_pkg::CNT_W'(pdl_pkg::MAX_PASSES))
    else $error("pass store count beyond capacity");

  a_no_commit_full: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !stat.full && !ovf_q)
    else $error("commit into a full pass store");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result overwrote an untaken transfer");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && last_q |=> count == '0 && deepest == '0)
    else $error("graph state not cleared after last pass");

endmodule

@@ hw/rtl/pass_dependency_leveler.sv @@
// Each accepted pass is compared against every pass stored so far in the
// current graph, one stored entry per cycle from the pass store memory; a
// pass that finds the store full is not compared or stored and is flagged
// as overflow. One pass is in work at a time, and the result register lets
// the next pass start while a finished result still waits to be taken. The
// pass marked last carries the level count and clears the graph.
module pass_dependency_leveler (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pdl_pkg::pdl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pdl_pkg::pdl_out_t out_data
);

  pdl_pkg::pdl_cmd_t  cmd;
  pdl_pkg::pdl_stat_t stat;

  pdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pdl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
